[rtl/ffba_pkg.sv]
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants and types for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int TAG_W      = 16;
  localparam int AMT_W      = 16;
  localparam int OUT_SIZE_W = 16;
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NOFIT = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_ALLOC = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the accepted beat
    logic compare;  // register the fit vector
    logic commit;   // pick first fit, update table, register result
  } ffba_cmd_t;

endpackage

[rtl/ffba_ctrl.sv]
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer: idle, compare, commit; drives busy and the result strobe.
// ----------------------------------------------------------------------------
module ffba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  output ffba_pkg::ffba_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_SEL  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.compare = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = ST_SEL;
      end
      ST_SEL: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.commit;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/ffba_dp.sv]
// ----------------------------------------------------------------------------
// ffba_dp
// Block table cells, parallel fit compare, first-fit pick and update.
// ----------------------------------------------------------------------------
module ffba_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ffba_pkg::ffba_cmd_t             cmd,
  input  logic                            in_mode,
  input  logic [ffba_pkg::TAG_W-1:0]      in_block_tag,
  input  logic [ffba_pkg::AMT_W-1:0]      in_amount,
  output logic [1:0]                      out_status,
  output logic [ffba_pkg::TAG_W-1:0]      out_granted_tag,
  output logic [ffba_pkg::OUT_SIZE_W-1:0] out_granted_size
);

  localparam int N  = ffba_pkg::MAX_BLOCKS;
  localparam int SW = ffba_pkg::SIZE_BITS;
  localparam int CW = ffba_pkg::CNT_W;
  localparam int TW = ffba_pkg::TAG_W;
  localparam int OW = ffba_pkg::OUT_SIZE_W;

  logic          req_mode_r;
  logic [TW-1:0] req_tag_r;
  logic [SW-1:0] req_amt_r;
  logic [N-1:0]  fit_r, fit_nxt;
  logic [CW-1:0] count_r;
  logic [TW-1:0] tags_r  [N];
  logic [SW-1:0] sizes_r [N];
  logic [1:0]    status_r;
  logic [TW-1:0] gtag_r;
  logic [OW-1:0] gsize_r;

  logic [N-1:0]  first;
  logic          any_fit;
  logic          full;
  logic [TW-1:0] sel_tag;
  logic [SW-1:0] sel_size;

  // Each valid cell compares its size against the request.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      fit_nxt[i] = (CW'(i) < count_r) && (sizes_r[i] >= req_amt_r);
    end
  end

  // Isolate the lowest set bit: the first fit in insertion order.
  assign first   = fit_r & (~fit_r + N'(1));
  assign any_fit = |fit_r;
  assign full    = (count_r >= CW'(N));

  always_comb begin
    sel_tag  = '0;
    sel_size = '0;
    for (int i = 0; i < N; i++) begin
      sel_tag  = sel_tag  | (first[i] ? tags_r[i]  : '0);
      sel_size = sel_size | (first[i] ? sizes_r[i] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit && req_mode_r == ffba_pkg::MODE_ADD && !full) begin
      count_r <= count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode_r <= in_mode;
      req_tag_r  <= in_block_tag;
      req_amt_r  <= SW'(in_amount);
    end
    if (cmd.compare) begin
      fit_r <= fit_nxt;
    end
    if (cmd.commit) begin
      if (req_mode_r == ffba_pkg::MODE_ADD) begin
        status_r <= full ? ffba_pkg::STAT_FULL : ffba_pkg::STAT_OK;
        gtag_r   <= '0;
        gsize_r  <= '0;
        for (int i = 0; i < N; i++) begin
          if (!full && CW'(i) == count_r) begin
            tags_r[i]  <= req_tag_r;
            sizes_r[i] <= req_amt_r;
          end
        end
      end else begin
        status_r <= any_fit ? ffba_pkg::STAT_OK : ffba_pkg::STAT_NOFIT;
        gtag_r   <= sel_tag;
        gsize_r  <= OW'(sel_size);
        for (int i = 0; i < N; i++) begin
          if (first[i]) begin
            sizes_r[i] <= sizes_r[i] - req_amt_r;
          end
        end
      end
    end
  end

  assign out_status       = status_r;
  assign out_granted_tag  = gtag_r;
  assign out_granted_size = gsize_r;

endmodule

[rtl/first_fit_block_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// The result strobe is registered from the commit step, after the start beat is
// captured and the controller's compare step registers the fit vector of the
// block table cells. A beat is taken only in idle, so each finishes first.
// Reset (synchronous, active low) empties the table; entry cells keep no reset.
// The receiver cannot stall: the result strobe is high for exactly one cycle.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_mode,
  input  logic [ffba_pkg::TAG_W-1:0]      in_block_tag,
  input  logic [ffba_pkg::AMT_W-1:0]      in_amount,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic [ffba_pkg::TAG_W-1:0]      out_granted_tag,
  output logic [ffba_pkg::OUT_SIZE_W-1:0] out_granted_size
);

  // Commands from the sequencer to the table datapath.
  ffba_pkg::ffba_cmd_t cmd;

  // Sequence each beat: capture, compare all cells, commit and strobe.
  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Hold the table; the commit step appends, or picks the first fit and cuts it.
  ffba_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_mode          (in_mode),
    .in_block_tag     (in_block_tag),
    .in_amount        (in_amount),
    .out_status       (out_status),
    .out_granted_tag  (out_granted_tag),
    .out_granted_size (out_granted_size)
  );

endmodule
